>>> sv/bat_pkg.sv
// Shared types and constants for the buddy allocator tree core.
// Node state codes, request codes and the size-to-level helper.
// No dependencies.
package bat_pkg;

   typedef enum logic [1:0] {
      NODE_ABSENT = 2'd0,
      NODE_FREE   = 2'd1,
      NODE_OCC    = 2'd2,
      NODE_SPLIT  = 2'd3
   } node_type;

   // one memory word holds a sibling pair: even node in [1:0], odd node in [3:2]
   typedef logic [3:0] pair_type;

   localparam logic [1:0] REQ_ALLOC    = 2'd0;
   localparam logic [1:0] REQ_FREE     = 2'd1;
   localparam logic [1:0] REQ_COLLAPSE = 2'd2;

   // ceil(log2(size)), with sizes zero and one giving zero
   function automatic logic [4:0] ceil_log2_16(input logic [15:0] size);
      logic [15:0] m;
      logic [4:0]  r;
      m = size - 16'd1;
      r = 5'd0;
      if (size > 16'd1) begin
         for (int b = 0; b < 16; b++) begin
            if (m[b]) r = 5'(b + 1);
         end
      end
      return r;
   endfunction

endpackage

>>> sv/buddy_allocator_tree_core.sv
// Buddy allocator over a heap-ordered tree of node states held in bat_ram.
// Depends on bat_pkg and bat_ram.
//
//   channel | direction | tdata                                     | tuser
//   req_    | in        | [15:0] request_size, [30:16] release_index | [1:0] req_type
//   rsp_    | out       | [14:0] node, [28:15] offset, [43:29] sz   | [0] ok
//
// Steps: allocate reads and evaluates each node on the depth-first walk, writes the
// child pair where a free node is split, and backtracks a step at a time; free reads
// one node and marks it free unless absent; collapse reads each internal node and its
// child pair, from the last one back to the root, clearing the pair where they merge.
// After reset a clearing pass writes all HEAP_BYTES / MIN_BLOCK pair words before the
// first request is taken. A new request is taken while a response waits.
module buddy_allocator_tree_core import bat_pkg::*; #(
   parameter int HEAP_BYTES = 16384,
   parameter int MIN_BLOCK  = 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // request_size, release_index, zero pad
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // node_index, block_offset, block_bytes, zero pad
   output logic        rsp_tuser    // ok
);

   localparam int LOGH  = $clog2(HEAP_BYTES);
   localparam int LOGM  = $clog2(MIN_BLOCK);
   localparam int LOGN  = LOGH - LOGM;
   localparam int NW    = LOGN + 1;
   localparam int PAW   = (LOGN > 0) ? LOGN : 1;
   localparam int DW    = (LOGN > 0) ? $clog2(LOGN + 1) : 1;
   localparam int PAIRS = 1 << LOGN;

   typedef enum logic [13:0] {
      ST_CLEAR = 14'b00000000000001,
      ST_IDLE  = 14'b00000000000010,
      ST_PREP  = 14'b00000000000100,
      ST_SRD   = 14'b00000000001000,
      ST_SEV   = 14'b00000000010000,
      ST_SSPL  = 14'b00000000100000,
      ST_SBT   = 14'b00000001000000,
      ST_FRD   = 14'b00000010000000,
      ST_FEV   = 14'b00000100000000,
      ST_CRD1  = 14'b00001000000000,
      ST_CRD2  = 14'b00010000000000,
      ST_CEV   = 14'b00100000000000,
      ST_CWR   = 14'b01000000000000,
      ST_DONE  = 14'b10000000000000
   } state_type;

   state_type      state_ff, state_in;
   logic [NW-1:0]  idx_ff, idx_in;
   logic [DW-1:0]  depth_ff, depth_in;
   logic [DW-1:0]  td_ff, td_in;
   logic [4:0]     lw_ff, lw_in;
   logic [1:0]     type_ff, type_in;
   logic [15:0]    size_ff, size_in;
   logic [14:0]    fidx_ff, fidx_in;
   pair_type       hold_ff, hold_in;
   logic [PAW-1:0] clr_ff, clr_in;

   logic           res_ok_ff, res_ok_in;
   logic [14:0]    res_node_ff, res_node_in;
   logic [13:0]    res_off_ff, res_off_in;
   logic [14:0]    res_bytes_ff, res_bytes_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_ok_ff, rsp_ok_in;
   logic [47:0]    rsp_data_ff, rsp_data_in;

   logic           mem_we, mem_re;
   logic [PAW-1:0] mem_waddr, mem_raddr;
   pair_type       mem_wdata, mem_rdata;

   node_type       cur_s, kid0_s, kid1_s;
   logic [4:0]     lw_raw, lw_eff;
   logic [LOGH:0]  off_wide;

   bat_ram #(.AW(PAW)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   function automatic pair_type put_slot(pair_type p, logic odd, node_type v);
      pair_type r;
      r = p;
      if (odd) r[3:2] = v;
      else     r[1:0] = v;
      return r;
   endfunction

   assign cur_s  = node_type'(idx_ff[0] ? mem_rdata[3:2] : mem_rdata[1:0]);
   assign kid0_s = node_type'(mem_rdata[1:0]);
   assign kid1_s = node_type'(mem_rdata[3:2]);
   assign lw_raw = ceil_log2_16(size_ff);
   assign lw_eff = (int'(lw_raw) < LOGM) ? 5'(LOGM) : lw_raw;
   assign off_wide = (LOGH + 1)'(idx_ff) << (LOGH - int'(depth_ff));

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      depth_in     = depth_ff;
      td_in        = td_ff;
      lw_in        = lw_ff;
      type_in      = type_ff;
      size_in      = size_ff;
      fidx_in      = fidx_ff;
      hold_in      = hold_ff;
      clr_in       = clr_ff;
      res_ok_in    = res_ok_ff;
      res_node_in  = res_node_ff;
      res_off_in   = res_off_ff;
      res_bytes_in = res_bytes_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            // pair zero carries the root in its odd slot
            mem_wdata = (clr_ff == '0) ? put_slot('0, 1'b1, NODE_FREE) : '0;
            clr_in    = clr_ff + PAW'(1);
            if (clr_ff == PAW'(PAIRS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               type_in  = req_tuser;
               size_in  = req_tdata[15:0];
               fidx_in  = req_tdata[30:16];
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            res_ok_in    = 1'b0;
            res_node_in  = '0;
            res_off_in   = '0;
            res_bytes_in = '0;
            priority if (type_ff == REQ_ALLOC) begin
               lw_in    = lw_eff;
               td_in    = DW'(LOGH - int'(lw_eff));
               idx_in   = NW'(1);
               depth_in = '0;
               state_in = (int'(lw_eff) > LOGH) ? ST_DONE : ST_SRD;
            end else if (type_ff == REQ_FREE) begin
               idx_in   = NW'(fidx_ff);
               state_in = (fidx_ff != '0 && int'(fidx_ff) < 2 * PAIRS) ? ST_FRD : ST_DONE;
            end else if (type_ff == REQ_COLLAPSE) begin
               res_ok_in = 1'b1;
               idx_in    = NW'(PAIRS - 1);
               state_in  = (PAIRS > 1) ? ST_CRD1 : ST_DONE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SRD: begin
            mem_re    = 1'b1;
            mem_raddr = PAW'(idx_ff >> 1);
            state_in  = ST_SEV;
         end
         ST_SEV: begin
            mem_waddr = PAW'(idx_ff >> 1);
            if (depth_ff == td_ff) begin
               if (cur_s == NODE_FREE) begin
                  mem_we       = 1'b1;
                  mem_wdata    = put_slot(mem_rdata, idx_ff[0], NODE_OCC);
                  res_ok_in    = 1'b1;
                  res_node_in  = 15'(idx_ff);
                  res_off_in   = 14'(off_wide[LOGH-1:0]);
                  res_bytes_in = 15'(32'd1 << lw_ff);
                  state_in     = ST_DONE;
               end else begin
                  state_in = ST_SBT;
               end
            end else begin
               unique case (cur_s)
                  NODE_FREE: begin
                     mem_we    = 1'b1;
                     mem_wdata = put_slot(mem_rdata, idx_ff[0], NODE_SPLIT);
                     state_in  = ST_SSPL;
                  end
                  NODE_SPLIT: begin
                     idx_in   = NW'({idx_ff, 1'b0});
                     depth_in = depth_ff + DW'(1);
                     state_in = ST_SRD;
                  end
                  default: state_in = ST_SBT;
               endcase
            end
         end
         ST_SSPL: begin
            mem_we    = 1'b1;
            mem_waddr = PAW'(idx_ff);
            mem_wdata = {NODE_FREE, NODE_FREE};
            idx_in    = NW'({idx_ff, 1'b0});
            depth_in  = depth_ff + DW'(1);
            state_in  = ST_SRD;
         end
         ST_SBT: begin
            // left child moves to its sibling, right child climbs to its parent
            priority if (idx_ff == NW'(1)) begin
               state_in = ST_DONE;
            end else if (!idx_ff[0]) begin
               idx_in   = idx_ff + NW'(1);
               state_in = ST_SRD;
            end else begin
               idx_in   = idx_ff >> 1;
               depth_in = depth_ff - DW'(1);
            end
         end
         ST_FRD: begin
            mem_re    = 1'b1;
            mem_raddr = PAW'(idx_ff >> 1);
            state_in  = ST_FEV;
         end
         ST_FEV: begin
            if (cur_s != NODE_ABSENT) begin
               mem_we    = 1'b1;
               mem_waddr = PAW'(idx_ff >> 1);
               mem_wdata = put_slot(mem_rdata, idx_ff[0], NODE_FREE);
               res_ok_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_CRD1: begin
            mem_re    = 1'b1;
            mem_raddr = PAW'(idx_ff >> 1);
            state_in  = ST_CRD2;
         end
         ST_CRD2: begin
            mem_re    = 1'b1;
            mem_raddr = PAW'(idx_ff);
            hold_in   = mem_rdata;
            state_in  = ST_CEV;
         end
         ST_CEV: begin
            if (node_type'(idx_ff[0] ? hold_ff[3:2] : hold_ff[1:0]) == NODE_SPLIT &&
                kid0_s == NODE_FREE && kid1_s == NODE_FREE) begin
               mem_we    = 1'b1;
               mem_waddr = PAW'(idx_ff >> 1);
               mem_wdata = put_slot(hold_ff, idx_ff[0], NODE_FREE);
               state_in  = ST_CWR;
            end else if (idx_ff == NW'(1)) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff - NW'(1);
               state_in = ST_CRD1;
            end
         end
         ST_CWR: begin
            mem_we    = 1'b1;
            mem_waddr = PAW'(idx_ff);
            mem_wdata = {NODE_ABSENT, NODE_ABSENT};
            if (idx_ff == NW'(1)) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff - NW'(1);
               state_in = ST_CRD1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_data_in  = {4'd0, res_bytes_ff, res_off_ff, res_node_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      depth_ff     <= depth_in;
      td_ff        <= td_in;
      lw_ff        <= lw_in;
      type_ff      <= type_in;
      size_ff      <= size_in;
      fidx_ff      <= fidx_in;
      hold_ff      <= hold_in;
      res_ok_ff    <= res_ok_in;
      res_node_ff  <= res_node_in;
      res_off_ff   <= res_off_in;
      res_bytes_ff <= res_bytes_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

   // a node at depth d has its leading one at bit d
   a_idx_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEV) |-> ((idx_ff >> depth_ff) == NW'(1)))
      else $error("node index does not match its depth");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write of one pair in the same cycle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_data_ff == '0))
      else $error("failed response carries a block");

   a_descent_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SSPL) |=> (depth_ff <= td_ff))
      else $error("split descended below the wanted size");

endmodule

>>> sv/bat_ram.sv
// Node-state memory: one sibling pair per word, one write and one read port.
// Read data is registered. Depends on bat_pkg.
module bat_ram import bat_pkg::*; #(
   parameter int AW = 14
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  pair_type      wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output pair_type      rdata
);

   pair_type mem [2**AW];
   pair_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
